FILE: hdl/psb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_pkg
// Shared types, constants and helpers for the sphere bounce particle step.
// ----------------------------------------------------------------------------
package psb_pkg;

   localparam int unsigned RADIUS_W = 31;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned CSR_IDX_W = 1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY = 1'b1;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 31'd1073741824;
   localparam logic [DATA_W-1:0]   GRAVITY_RESET = 32'd26844;

   // divider geometry: the correction term stays below 2^34
   localparam int unsigned QUO_W = 34;
   localparam int unsigned DEN_W = 64;
   localparam int unsigned NUM_W = 97;

   typedef struct packed {
      logic                     mode;
      logic signed [31:0]       pos_x;
      logic signed [31:0]       pos_y;
      logic signed [31:0]       pos_z;
      logic signed [31:0]       vel_x;
      logic signed [31:0]       vel_y;
      logic signed [31:0]       vel_z;
      logic [30:0]              flake_size;
      logic                     last_in_frame;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0]       new_pos_x;
      logic signed [31:0]       new_pos_y;
      logic signed [31:0]       new_pos_z;
      logic signed [31:0]       new_vel_x;
      logic signed [31:0]       new_vel_y;
      logic signed [31:0]       new_vel_z;
      logic                     hit_boundary;
      logic                     frame_done;
   } rsp_word_type;

   // what the front stages hand to the reflection stages
   typedef struct packed {
      logic [2:0][31:0]         p;
      logic [2:0][31:0]         v;
      logic [31:0]              vy_in;
      logic [2:0][31:0]         q;
      logic [2:0][31:0]         pabs;
      logic [2:0]               pneg;
      logic                     hit;
      logic                     reflect;
      logic                     pp_zero;
      logic                     dneg;
      logic [63:0]              mag;
      logic [63:0]              pp;
      logic                     last;
   } front_word_type;

   function automatic logic [31:0] sat33(input logic [32:0] x);
      logic [31:0] r;
      if (x[32] != x[31]) begin
         r = x[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] sat36(input logic [35:0] x);
      logic [31:0] r;
      if (x[35] && !(&x[34:31])) begin
         r = 32'h8000_0000;
      end else if (!x[35] && (|x[34:31])) begin
         r = 32'h7fff_ffff;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] abs32(input logic [31:0] x);
      return x[31] ? (~x + 32'd1) : x;
   endfunction

endpackage

FILE: hdl/psb_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb channels
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface psb_req_if;
   logic                  valid;
   logic                  ready;
   psb_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface psb_rsp_if;
   logic                  valid;
   logic                  ready;
   psb_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/psb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_front
// Capture, trial move, products and sums, boundary decision (five stages).
// ----------------------------------------------------------------------------
module psb_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  psb_pkg::req_word_type   in_word,
   input  logic [30:0]             radius,
   input  logic [31:0]             gravity,
   output logic                    out_valid,
   output psb_pkg::front_word_type out_word
);

   typedef struct packed {
      logic [2:0][31:0] p;
      logic [2:0][31:0] v;
      logic [31:0]      vy_in;
      logic [2:0][31:0] q;
      logic [30:0]      size;
      logic             reflect;
      logic             last;
   } move_type;

   typedef struct packed {
      logic [2:0][31:0] p;
      logic [2:0][31:0] v;
      logic [31:0]      vy_in;
      logic [2:0][31:0] q;
      logic [2:0][31:0] pabs;
      logic [2:0]       pneg;
      logic [2:0][63:0] qsq;
      logic [2:0][63:0] pv;
      logic [2:0]       pvneg;
      logic [2:0][63:0] ppi;
      logic             big;
      logic [30:0]      d;
      logic             reflect;
      logic             last;
   } prod_type;

   typedef struct packed {
      logic [2:0][31:0] p;
      logic [2:0][31:0] v;
      logic [31:0]      vy_in;
      logic [2:0][31:0] q;
      logic [2:0][31:0] pabs;
      logic [2:0]       pneg;
      logic [63:0]      s;
      logic [63:0]      dd;
      logic [63:0]      pos;
      logic [63:0]      neg;
      logic [63:0]      pp;
      logic             big;
      logic             reflect;
      logic             last;
   } sum_type;

   psb_pkg::req_word_type   a_ff;
   logic                    a_vld_ff;
   move_type                b_ff, b_in;
   logic                    b_vld_ff;
   prod_type                c_ff, c_in;
   logic                    c_vld_ff;
   sum_type                 d_ff, d_in;
   logic                    d_vld_ff;
   psb_pkg::front_word_type e_ff, e_in;
   logic                    e_vld_ff;

   // stage b: gravity, trial position, floor test
   always_comb begin
      logic [32:0] vy_sum;
      logic [32:0] qs;
      logic signed [34:0] py_ext;
      logic signed [34:0] py5;
      b_in       = '0;
      b_in.p[0]  = a_ff.pos_x;
      b_in.p[1]  = a_ff.pos_y;
      b_in.p[2]  = a_ff.pos_z;
      b_in.v[0]  = a_ff.vel_x;
      b_in.v[2]  = a_ff.vel_z;
      b_in.vy_in = a_ff.vel_y;
      vy_sum = {a_ff.vel_y[31], a_ff.vel_y} + {gravity[31], gravity};
      b_in.v[1] = a_ff.mode ? psb_pkg::sat33(vy_sum) : a_ff.vel_y;
      for (int i = 0; i < 3; i++) begin
         qs = {b_in.p[i][31], b_in.p[i]} + {b_in.v[i][31], b_in.v[i]};
         b_in.q[i] = psb_pkg::sat33(qs);
      end
      py_ext = {{3{a_ff.pos_y[31]}}, a_ff.pos_y};
      py5 = (py_ext <<< 2) + py_ext;
      b_in.reflect = !a_ff.mode || (py5 < $signed({4'b0, radius}));
      b_in.size = a_ff.flake_size;
      b_in.last = a_ff.last_in_frame;
   end

   // stage c: magnitudes and products
   always_comb begin
      logic [31:0] qa;
      logic [31:0] va;
      c_in       = '0;
      c_in.p     = b_ff.p;
      c_in.v     = b_ff.v;
      c_in.vy_in = b_ff.vy_in;
      c_in.q     = b_ff.q;
      for (int i = 0; i < 3; i++) begin
         qa = psb_pkg::abs32(b_ff.q[i]);
         va = psb_pkg::abs32(b_ff.v[i]);
         c_in.pabs[i]  = psb_pkg::abs32(b_ff.p[i]);
         c_in.pneg[i]  = b_ff.p[i][31];
         c_in.qsq[i]   = qa * qa;
         c_in.pv[i]    = c_in.pabs[i] * va;
         c_in.pvneg[i] = b_ff.p[i][31] ^ b_ff.v[i][31];
         c_in.ppi[i]   = c_in.pabs[i] * c_in.pabs[i];
      end
      c_in.big     = b_ff.size >= radius;
      c_in.d       = radius - b_ff.size;
      c_in.reflect = b_ff.reflect;
      c_in.last    = b_ff.last;
   end

   // stage d: sums
   always_comb begin
      logic [61:0] dsq;
      d_in       = '0;
      d_in.p     = c_ff.p;
      d_in.v     = c_ff.v;
      d_in.vy_in = c_ff.vy_in;
      d_in.q     = c_ff.q;
      d_in.pabs  = c_ff.pabs;
      d_in.pneg  = c_ff.pneg;
      d_in.s     = c_ff.qsq[0] + c_ff.qsq[1] + c_ff.qsq[2];
      d_in.pp    = c_ff.ppi[0] + c_ff.ppi[1] + c_ff.ppi[2];
      for (int i = 0; i < 3; i++) begin
         if (c_ff.pvneg[i]) begin
            d_in.neg = d_in.neg + c_ff.pv[i];
         end else begin
            d_in.pos = d_in.pos + c_ff.pv[i];
         end
      end
      dsq = c_ff.d * c_ff.d;
      d_in.dd      = {2'b0, dsq};
      d_in.big     = c_ff.big;
      d_in.reflect = c_ff.reflect;
      d_in.last    = c_ff.last;
   end

   // stage e: boundary decision and signed dot product
   always_comb begin
      e_in         = '0;
      e_in.p       = d_ff.p;
      e_in.v       = d_ff.v;
      e_in.vy_in   = d_ff.vy_in;
      e_in.q       = d_ff.q;
      e_in.pabs    = d_ff.pabs;
      e_in.pneg    = d_ff.pneg;
      e_in.hit     = d_ff.big || (d_ff.s >= d_ff.dd);
      e_in.reflect = d_ff.reflect;
      e_in.pp_zero = d_ff.pp == 64'd0;
      e_in.dneg    = d_ff.pos < d_ff.neg;
      e_in.mag     = e_in.dneg ? (d_ff.neg - d_ff.pos) : (d_ff.pos - d_ff.neg);
      e_in.pp      = d_ff.pp;
      e_in.last    = d_ff.last;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= in_word;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
         e_ff <= e_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
      end
   end

   assign out_valid = e_vld_ff;
   assign out_word  = e_ff;

endmodule

FILE: hdl/psb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psb_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module psb_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [psb_pkg::NUM_W-1:0]  num,
   input  logic [psb_pkg::DEN_W-1:0]  den,
   output logic [psb_pkg::QUO_W-1:0]  quo
);

   localparam int unsigned QW = psb_pkg::QUO_W;
   localparam int unsigned NW = psb_pkg::NUM_W;
   localparam int unsigned DW = psb_pkg::DEN_W;

   logic [NW-1:0] rem_ff [QW];
   logic [DW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [NW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [QW-1:0] quo_src;
      logic [NW:0]   diff;
      logic [NW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (s == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign den_src = den_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      // trial subtract of the divisor aligned to this quotient bit
      assign diff   = {1'b0, rem_src} - ({{(NW + 1 - DW){1'b0}}, den_src} << (QW - 1 - s));
      assign rem_in = diff[NW] ? rem_src : diff[NW-1:0];
      assign quo_in = diff[NW] ? quo_src : (quo_src | (QW'(1) << (QW - 1 - s)));

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_src;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

FILE: hdl/particle_sphere_bounce_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_sphere_bounce_step_top
// One particle step inside a sphere, with boundary reflection, Q2.30.
//
//   channel   dir   handshake        word
//   req_ch    in    valid/ready      req_word_type (one particle)
//   rsp_ch    out   valid/ready      rsp_word_type (one result per particle)
//   csr_*     in    csr_we           index + 32-bit data, write only
//
// A new word enters every cycle unless the output word waits; the 34-stage
// quotient pipeline sits behind 5 front stages and 2 numerator stages.
// Reset is synchronous, clears valid bits and loads the two registers' reset values.
// The whole pipeline holds while the output word waits to be taken.
// ----------------------------------------------------------------------------
module particle_sphere_bounce_step_top (
   input  logic                             clock,
   input  logic                             reset,
   psb_req_if.sink                          req_ch,
   psb_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic [psb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [psb_pkg::DATA_W-1:0]       csr_wdata
);

   localparam int unsigned QW = psb_pkg::QUO_W;

   logic [30:0]             radius_ff;
   logic [31:0]             gravity_ff;
   logic                    en;
   logic                    fr_vld;
   psb_pkg::front_word_type fr_word;

   logic                    f_vld_ff;
   psb_pkg::front_word_type f_ff;
   logic [2:0][63:0]        lo_ff, hi_ff;
   logic                    g_vld_ff;
   psb_pkg::front_word_type g_ff;
   logic [2:0][psb_pkg::NUM_W-1:0] num_ff;

   logic                    dv_vld_ff [QW];
   psb_pkg::front_word_type side_ff [QW];
   logic [2:0][QW-1:0]      quo;

   logic                    out_vld_ff;
   psb_pkg::rsp_word_type   rsp_ff, rsp_in;

   assign en = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= psb_pkg::RADIUS_RESET;
         gravity_ff <= psb_pkg::GRAVITY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            psb_pkg::CSR_RADIUS: begin
               radius_ff <= csr_wdata[30:0];
            end
            psb_pkg::CSR_GRAVITY: begin
               gravity_ff <= csr_wdata;
            end
            default: begin
               radius_ff <= radius_ff;
            end
         endcase
      end
   end

   psb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .in_word   (req_ch.data),
      .radius    (radius_ff),
      .gravity   (gravity_ff),
      .out_valid (fr_vld),
      .out_word  (fr_word)
   );

   // numerator 2*|p.v|*|p_i| as two 32x32 partial products, then summed
   always_ff @(posedge clock) begin
      if (en) begin
         f_ff <= fr_word;
         for (int i = 0; i < 3; i++) begin
            lo_ff[i] <= fr_word.mag[31:0] * fr_word.pabs[i];
            hi_ff[i] <= fr_word.mag[63:32] * fr_word.pabs[i];
         end
         g_ff <= f_ff;
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= {({32'b0, hi_ff[i]} << 32) + {32'b0, lo_ff[i]}, 1'b0};
         end
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      psb_div u_div (
         .clock (clock),
         .en    (en),
         .num   (num_ff[i]),
         .den   (g_ff.pp),
         .quo   (quo[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= g_ff;
         for (int s = 1; s < QW; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff   <= 1'b0;
         g_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int s = 0; s < QW; s++) begin
            dv_vld_ff[s] <= 1'b0;
         end
      end else if (en) begin
         f_vld_ff     <= fr_vld;
         g_vld_ff     <= f_vld_ff;
         dv_vld_ff[0] <= g_vld_ff;
         for (int s = 1; s < QW; s++) begin
            dv_vld_ff[s] <= dv_vld_ff[s-1];
         end
         out_vld_ff <= dv_vld_ff[QW-1];
      end
   end

   // final select: trial move, reflection or gravity taken off
   always_comb begin
      psb_pkg::front_word_type sd;
      logic [2:0][31:0] r;
      logic [2:0][31:0] nv;
      logic [35:0] vext;
      logic [35:0] text;
      sd = side_ff[QW-1];
      for (int i = 0; i < 3; i++) begin
         vext = {{4{sd.v[i][31]}}, sd.v[i]};
         text = {2'b0, quo[i]};
         r[i] = psb_pkg::sat36((sd.dneg ^ sd.pneg[i]) ? (vext + text) : (vext - text));
      end
      if (!sd.hit) begin
         nv = sd.v;
      end else if (sd.reflect) begin
         nv = sd.pp_zero ? sd.v : r;
      end else begin
         nv    = sd.v;
         nv[1] = sd.vy_in;
      end
      rsp_in.new_pos_x    = sd.hit ? sd.p[0] : sd.q[0];
      rsp_in.new_pos_y    = sd.hit ? sd.p[1] : sd.q[1];
      rsp_in.new_pos_z    = sd.hit ? sd.p[2] : sd.q[2];
      rsp_in.new_vel_x    = nv[0];
      rsp_in.new_vel_y    = nv[1];
      rsp_in.new_vel_z    = nv[2];
      rsp_in.hit_boundary = sd.hit;
      rsp_in.frame_done   = sd.last;
   end

   assign rsp_ch.valid = out_vld_ff;
   assign rsp_ch.data  = rsp_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !out_vld_ff)
      else $error("output word valid right after reset");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(dv_vld_ff[QW-1]) && $stable(g_vld_ff) && $stable(f_vld_ff))
      else $error("pipeline valid bits moved during a stall");

   a_tail_lands: assert property (@(posedge clock) disable iff (reset)
      en && dv_vld_ff[QW-1] |=> out_vld_ff)
      else $error("word leaving the divider did not reach the output");

   a_zero_pos_keeps_vel: assert property (@(posedge clock) disable iff (reset)
      en && dv_vld_ff[QW-1] && side_ff[QW-1].hit && side_ff[QW-1].reflect
      && side_ff[QW-1].pp_zero |=> rsp_ff.new_vel_x == $past(side_ff[QW-1].v[0]))
      else $error("reflection at zero position changed the velocity");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for particle_sphere_bounce_step_top
// Streams particles through the block under random idling on both channels,
// predicts each updated particle in a scoreboard and compares every field.
// ----------------------------------------------------------------------------
module testbench;

   class bounce_scoreboard;
      logic [30:0]           radius;
      longint                gravity;
      psb_pkg::rsp_word_type expected_q[$];
      int                    errors;

      function new();
         radius  = psb_pkg::RADIUS_RESET;
         gravity = longint'($signed(psb_pkg::GRAVITY_RESET));
         errors  = 0;
      endfunction

      function longint clamp32(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      function logic [63:0] mag(longint x);
         return x < 0 ? 64'(-x) : 64'(x);
      endfunction

      // works out the updated particle and queues it
      function void note_particle(psb_pkg::req_word_type w);
         longint       p[3], v[3], q[3], np[3], nv[3], t;
         logic [65:0]  s, d, pos, neg, pp, dmag, m;
         logic [129:0] num;
         bit           hit, dneg, sneg;
         psb_pkg::rsp_word_type r;
         p[0] = w.pos_x; p[1] = w.pos_y; p[2] = w.pos_z;
         v[0] = w.vel_x; v[1] = w.vel_y; v[2] = w.vel_z;
         if (w.mode) v[1] = clamp32(v[1] + gravity);
         for (int i = 0; i < 3; i++) q[i] = clamp32(p[i] + v[i]);
         if (w.flake_size >= radius) begin
            hit = 1;
         end else begin
            s = 0;
            for (int i = 0; i < 3; i++) s += 66'(mag(q[i])) * 66'(mag(q[i]));
            d = 66'(radius - w.flake_size);
            hit = s >= d * d;
         end
         for (int i = 0; i < 3; i++) begin
            np[i] = hit ? p[i] : q[i];
            nv[i] = v[i];
         end
         if (hit && (!w.mode || 5 * p[1] < longint'(radius))) begin
            pos = 0; neg = 0; pp = 0;
            for (int i = 0; i < 3; i++) begin
               m = 66'(mag(p[i])) * 66'(mag(v[i]));
               if ((p[i] < 0) != (v[i] < 0)) neg += m; else pos += m;
               pp += 66'(mag(p[i])) * 66'(mag(p[i]));
            end
            // zero position keeps the velocity as it stands
            if (pp != 0) begin
               dneg = pos < neg;
               dmag = dneg ? neg - pos : pos - neg;
               for (int i = 0; i < 3; i++) begin
                  num  = (130'(dmag) << 1) * 130'(mag(p[i]));
                  num  = num / 130'(pp);
                  t    = longint'(num[63:0]);
                  sneg = dneg != (p[i] < 0);
                  nv[i] = clamp32(sneg ? v[i] + t : v[i] - t);
               end
            end
         end else if (hit) begin
            nv[1] = w.vel_y;  // gravity taken off again
         end
         r.new_pos_x = np[0][31:0]; r.new_pos_y = np[1][31:0]; r.new_pos_z = np[2][31:0];
         r.new_vel_x = nv[0][31:0]; r.new_vel_y = nv[1][31:0]; r.new_vel_z = nv[2][31:0];
         r.hit_boundary = hit;
         r.frame_done   = w.last_in_frame;
         expected_q.push_back(r);
      endfunction

      function void check_word(psb_pkg::rsp_word_type a);
         psb_pkg::rsp_word_type e;
         if (expected_q.size() == 0) begin
            $error("result word with nothing expected: %p", a);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (a.new_pos_x !== e.new_pos_x) begin
            $error("new_pos_x exp %0d got %0d", e.new_pos_x, a.new_pos_x); errors++;
         end
         if (a.new_pos_y !== e.new_pos_y) begin
            $error("new_pos_y exp %0d got %0d", e.new_pos_y, a.new_pos_y); errors++;
         end
         if (a.new_pos_z !== e.new_pos_z) begin
            $error("new_pos_z exp %0d got %0d", e.new_pos_z, a.new_pos_z); errors++;
         end
         if (a.new_vel_x !== e.new_vel_x) begin
            $error("new_vel_x exp %0d got %0d", e.new_vel_x, a.new_vel_x); errors++;
         end
         if (a.new_vel_y !== e.new_vel_y) begin
            $error("new_vel_y exp %0d got %0d", e.new_vel_y, a.new_vel_y); errors++;
         end
         if (a.new_vel_z !== e.new_vel_z) begin
            $error("new_vel_z exp %0d got %0d", e.new_vel_z, a.new_vel_z); errors++;
         end
         if (a.hit_boundary !== e.hit_boundary) begin
            $error("hit_boundary exp %0b got %0b", e.hit_boundary, a.hit_boundary); errors++;
         end
         if (a.frame_done !== e.frame_done) begin
            $error("frame_done exp %0b got %0b", e.frame_done, a.frame_done); errors++;
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          csr_we;
   logic [psb_pkg::CSR_IDX_W-1:0] csr_index;
   logic [psb_pkg::DATA_W-1:0]    csr_wdata;
   psb_req_if req_ch();
   psb_rsp_if rsp_ch();

   bounce_scoreboard sb = new();
   bit  calm;          // no idling on either side while set
   bit  rsp_taken;
   int  rsp_wait;
   longint cycles;

   particle_sphere_bounce_step_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 2000000) begin
         $display("particle_sphere_bounce_step_top: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_word(rsp_ch.data);
         rsp_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         rsp_wait = calm ? 0 : $urandom_range(0, 11);
      end
      if (rsp_wait > 0) begin
         rsp_ch.ready = 1'b0;
         rsp_wait--;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   task automatic write_reg(logic [psb_pkg::CSR_IDX_W-1:0] idx,
                            logic [psb_pkg::DATA_W-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == psb_pkg::CSR_RADIUS) sb.radius = value[30:0];
      else sb.gravity = longint'($signed(value));
   endtask

   // called at a falling edge; returns at a falling edge
   task automatic send_particle(psb_pkg::req_word_type w);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.data = w;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_particle(w);
      @(negedge clock);
   endtask

   task automatic drain;
      req_ch.valid = 1'b0;
      while (sb.expected_q.size() > 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_comp(logic [31:0] scale);
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2 * 255)) - 255);
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0;
               default: return 32'hffff_ffff;
            endcase
         end
         default: begin
            // inside the sphere: scaled down by a random shift
            logic [31:0] x;
            x = (scale >> $urandom_range(1, 4)) & $urandom();
            return $urandom_range(0, 1) ? -x : x;
         end
      endcase
   endfunction

   function automatic psb_pkg::req_word_type rand_particle();
      psb_pkg::req_word_type w;
      logic [31:0] sc;
      sc = {1'b0, sb.radius};
      w.mode = 1'($urandom_range(0, 1));
      w.pos_x = rand_comp(sc); w.pos_y = rand_comp(sc); w.pos_z = rand_comp(sc);
      // velocities mostly small so moves stay near the wall
      w.vel_x = rand_comp(sc >> 4); w.vel_y = rand_comp(sc >> 4);
      w.vel_z = rand_comp(sc >> 4);
      w.flake_size = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 4095));
      w.last_in_frame = $urandom_range(0, 15) == 0;
      return w;
   endfunction

   function automatic psb_pkg::req_word_type make_particle(bit m, logic [31:0] px, py, pz,
                                                  vx, vy, vz, logic [30:0] fs, bit last);
      psb_pkg::req_word_type w;
      w.mode = m; w.pos_x = px; w.pos_y = py; w.pos_z = pz;
      w.vel_x = vx; w.vel_y = vy; w.vel_z = vz;
      w.flake_size = fs; w.last_in_frame = last;
      return w;
   endfunction

   initial begin
      logic [30:0] radius_set[8];
      logic [31:0] gravity_set[8];
      cycles = 0;
      rsp_wait = 0;
      rsp_taken = 1'b0;
      calm = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed words under reset settings
      send_particle(make_particle(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_particle(make_particle(0, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0, 1));
      send_particle(make_particle(1, 0, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0));
      send_particle(make_particle(0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                  32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 1));
      send_particle(make_particle(0, 32'h3000_0000, 32'h1000_0000, 0,
                                  32'h2000_0000, 32'hf000_0000, 32'h100, 0, 0));
      send_particle(make_particle(1, 32'h100, 32'h3800_0000, 0, 0, 32'h1000_0000, 0, 0, 0));
      send_particle(make_particle(1, 32'h100, 32'hc000_0000, 0, 0, 32'hc000_0000, 0, 0, 0));
      send_particle(make_particle(1, 32'h1000, 32'h1000, 32'h1000, 5, 5, 5, 0, 0));
      send_particle(make_particle(0, 32'h1000, 32'h1000, 0, 1, 1, 1, 31'h7fff_ffff, 1));
      send_particle(make_particle(1, 32'h1000, 32'h2000_0000, 0, 1, 1, 1, 31'h4000_0000, 0));
      send_particle(make_particle(0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                                  31'h7fff_ffff, 1));
      send_particle(make_particle(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  31'h5555_5555, 0));
      send_particle(make_particle(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                  31'h2aaa_aaaa, 1));
      // the sender waits here for every result before going on
      drain();

      radius_set  = '{31'h4000_0000, 31'h0, 31'h7fff_ffff, 31'h1000_0000,
                      31'h4000_0000, 31'h0800_0000, 31'h7fff_ffff, 31'h0};
      gravity_set = '{32'd26844, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
                      32'hfff0_0000, 32'h0010_0000, 32'h8000_0000, 32'd26844};
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(psb_pkg::CSR_RADIUS, {1'b0, radius_set[ph]});
         write_reg(psb_pkg::CSR_GRAVITY, gravity_set[ph]);
         calm = (ph % 3 == 1);
         for (int n = 0; n < 250; n++) begin
            send_particle(rand_particle());
            if (n % 97 == 0) calm = !calm;
         end
         drain();
      end

      if (sb.errors == 0) begin
         $display("particle_sphere_bounce_step_top: match");
      end else begin
         $display("particle_sphere_bounce_step_top: mismatch");
      end
      $finish;
   end

endmodule
